### rtl/rvrc_pkg.sv
// rvrc_pkg: shared constants and types of the vertex index remap chunker
// used by the lane, merge and top-level modules; no dependencies

package rvrc_pkg;

   localparam int MAX_SOURCE_VERTS = 65536;
   localparam int CHUNK_LIMIT      = 65535;
   localparam int CORNERS          = 3;

   localparam int CORNER_W = 32;
   localparam int CNT_W    = 17;
   localparam int CHUNK_W  = 16;
   localparam int LOCAL_W  = 16;
   localparam int SRCOUT_W = 16;
   localparam int FILL_W   = 17;
   localparam int SRC_AW   = $clog2(MAX_SOURCE_VERTS);
   localparam int LIM_W    = (SRC_AW + 1 > CNT_W) ? SRC_AW + 1 : CNT_W;
   localparam int IDX_W    = $clog2(CORNERS);

   localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(65536);

   // per-corner classification from one lane
   typedef struct packed {
      logic             keep;
      logic             dup;
      logic [IDX_W-1:0] dup_sel;
   } lane_info_type;

   // one remap table entry
   typedef struct packed {
      logic               valid;
      logic [CHUNK_W-1:0] tag;
      logic [LOCAL_W-1:0] loc;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

endpackage

### rtl/vertex_index_remap_chunker.sv
// vertex_index_remap_chunker: top level, remaps 32-bit triangle corners into
// 16-bit chunk-local indices; depends on rvrc_pkg, rvrc_ram, rvrc_lane, rvrc_merge
//
// usage
//  - request: a triangle word (primitive flag, three corners) is taken at a
//    clock edge where start is high and busy is low
//  - response: one word per kept corner, in corner order, each shown for one
//    cycle with rsp_strobe high; rsp_last marks the final word of a triangle.
//    a triangle whose corners are all out of range gives no word
//  - csr: vertex_count write channel, csr_ready is always high; write it only
//    while busy is low
//  - output timing: each word is registered from its corner's step of the remap
//    table walk, so an out-of-range corner leaves a gap; a chunk number wrap puts
//    the clearing pass and the prep state, which reads corner a, before the walk
//  - triangles: the remap table walks the three corners one per cycle (read of
//    the next corner overlaps the write-back of the current one); a new triangle
//    is taken only in idle, once the walk is done and busy is low again
//  - reset: a clearing pass over all MAX_SOURCE_VERTS (65536) entries sweeps the
//    remap table; busy stays high through it. when the chunk number wraps to
//    zero the same pass runs before that triangle is processed
//  - the receiver cannot stall: words are never held back

module vertex_index_remap_chunker
   import rvrc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                start,
   output logic                busy,
   input  logic                req_primitive_start,
   input  logic [CORNER_W-1:0] req_corner_a,
   input  logic [CORNER_W-1:0] req_corner_b,
   input  logic [CORNER_W-1:0] req_corner_c,

   output logic                rsp_strobe,
   output logic [CHUNK_W-1:0]  rsp_chunk_number,
   output logic [LOCAL_W-1:0]  rsp_local_index,
   output logic [SRCOUT_W-1:0] rsp_source_index,
   output logic                rsp_new_vertex,
   output logic                rsp_last,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_W-1:0]    csr_vertex_count
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CLEAR = 4'b0010,
      ST_PREP  = 4'b0100,
      ST_RUN   = 4'b1000
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [SRC_AW-1:0]   clear_addr_ff, clear_addr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [CHUNK_W-1:0]  counter_ff, counter_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]    vcount_ff, vcount_in;
   logic                strobe_ff;

   // triangle being worked on
   logic [CORNER_W-1:0] corner_ff [CORNERS];
   logic [LOCAL_W-1:0]  loc_ff [CORNERS];

   // response payload
   logic [CHUNK_W-1:0]  chunk_ff;
   logic [LOCAL_W-1:0]  local_ff;
   logic [SRCOUT_W-1:0] source_ff;
   logic                new_ff;
   logic                last_ff;

   logic                accept;
   logic                run;
   logic [FILL_W:0]     fill_sum;
   logic                close_chunk;
   logic [CHUNK_W-1:0]  counter_next;
   logic [LIM_W-1:0]    vc_ext;
   logic [LIM_W-1:0]    limit;

   lane_info_type       lane_info [CORNERS];
   logic [CORNERS-1:0]  last_flag;
   lane_info_type       cur_info;
   logic [CORNER_W-1:0] cur_corner;
   logic [IDX_W-1:0]    rd_sel;

   logic                ram_wr_en;
   logic [SRC_AW-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [SRC_AW-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   slot_entry_type      rd_entry;
   slot_entry_type      wr_entry;
   logic                hit;
   logic                fresh;
   logic [LOCAL_W-1:0]  loc_sel;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign run       = (state_ff == ST_RUN);
   assign csr_ready = 1'b1;

   // vertex count, clamped to the table depth
   assign vc_ext = LIM_W'(vcount_ff);
   assign limit  = (vc_ext > LIM_W'(MAX_SOURCE_VERTS)) ? LIM_W'(MAX_SOURCE_VERTS) : vc_ext;

   // chunk check before the triangle; an empty chunk is never closed
   assign fill_sum     = (FILL_W + 1)'(fill_ff) + (FILL_W + 1)'(CORNERS);
   assign close_chunk  = (req_primitive_start || (fill_sum > (FILL_W + 1)'(CHUNK_LIMIT)))
                         && (fill_ff != '0);
   assign counter_next = CHUNK_W'(counter_ff + 1'b1);

   // one lane per corner, each sees the corners before it
   for (genvar k = 0; k < CORNERS; k++) begin : g_lane
      logic [CORNERS-2:0][CORNER_W-1:0] earlier;
      logic [CORNERS-2:0]               earlier_en;

      for (genvar i = 0; i < CORNERS - 1; i++) begin : g_prev
         assign earlier[i]    = corner_ff[i];
         assign earlier_en[i] = (i < k);
      end

      rvrc_lane u_lane (
         .corner     (corner_ff[k]),
         .limit      (limit),
         .earlier    (earlier),
         .earlier_en (earlier_en),
         .info       (lane_info[k])
      );
   end

   rvrc_merge u_merge (
      .info      (lane_info),
      .last_flag (last_flag)
   );

   // current corner and remap decision
   assign cur_info   = lane_info[step_ff];
   assign cur_corner = corner_ff[step_ff];
   assign rd_entry   = slot_entry_type'(ram_rd_data);
   assign hit        = rd_entry.valid && (rd_entry.tag == counter_ff);
   assign fresh      = run && cur_info.keep && !cur_info.dup && !hit;

   always_comb begin
      if (cur_info.dup) begin
         loc_sel = loc_ff[cur_info.dup_sel];
      end else if (hit) begin
         loc_sel = rd_entry.loc;
      end else begin
         loc_sel = fill_ff[LOCAL_W-1:0];
      end
   end

   // read the next corner while the current one is written back
   assign rd_sel = (step_ff == IDX_W'(CORNERS - 1)) ? step_ff : IDX_W'(step_ff + 1'b1);

   always_comb begin
      if (state_ff == ST_IDLE) begin
         ram_rd_addr = req_corner_a[SRC_AW-1:0];
      end else if (state_ff == ST_PREP) begin
         ram_rd_addr = corner_ff[0][SRC_AW-1:0];
      end else begin
         ram_rd_addr = corner_ff[rd_sel][SRC_AW-1:0];
      end
   end

   // clearing pass writes invalid entries, otherwise a miss appends
   always_comb begin
      wr_entry.valid = 1'b1;
      wr_entry.tag   = counter_ff;
      wr_entry.loc   = fill_ff[LOCAL_W-1:0];
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = fresh;
         ram_wr_addr = cur_corner[SRC_AW-1:0];
         ram_wr_data = ENTRY_W'(wr_entry);
      end
   end

   rvrc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SOURCE_VERTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      pend_in       = pend_ff;
      step_in       = step_ff;
      counter_in    = counter_ff;
      fill_in       = fill_ff;
      vcount_in     = vcount_ff;

      if (csr_valid) begin
         vcount_in = csr_vertex_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in  = '0;
               state_in = ST_RUN;
               if (close_chunk) begin
                  counter_in = counter_next;
                  fill_in    = '0;
                  // chunk number wrapped: old tags must not hit again
                  if (counter_next == '0) begin
                     state_in      = ST_CLEAR;
                     clear_addr_in = '0;
                     pend_in       = 1'b1;
                  end
               end
            end
         end
         ST_CLEAR: begin
            clear_addr_in = SRC_AW'(clear_addr_ff + 1'b1);
            if (clear_addr_ff == SRC_AW'(MAX_SOURCE_VERTS - 1)) begin
               state_in = pend_ff ? ST_PREP : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_PREP: begin
            step_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (fresh) begin
               fill_in = FILL_W'(fill_ff + 1'b1);
            end
            if (step_ff == IDX_W'(CORNERS - 1)) begin
               step_in  = '0;
               state_in = ST_IDLE;
            end else begin
               step_in = IDX_W'(step_ff + 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         pend_ff       <= 1'b0;
         step_ff       <= '0;
         counter_ff    <= '0;
         fill_ff       <= '0;
         vcount_ff     <= VCOUNT_RESET;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         pend_ff       <= pend_in;
         step_ff       <= step_in;
         counter_ff    <= counter_in;
         fill_ff       <= fill_in;
         vcount_ff     <= vcount_in;
         strobe_ff     <= run && cur_info.keep;
      end
   end

   // triangle capture and per-corner local index record
   always_ff @(posedge clock) begin
      if (accept) begin
         corner_ff[0] <= req_corner_a;
         corner_ff[1] <= req_corner_b;
         corner_ff[2] <= req_corner_c;
      end
      if (run) begin
         loc_ff[step_ff] <= loc_sel;
         chunk_ff        <= counter_ff;
         local_ff        <= loc_sel;
         source_ff       <= cur_corner[SRCOUT_W-1:0];
         new_ff          <= fresh;
         last_ff         <= last_flag[step_ff];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_chunk_number = chunk_ff;
   assign rsp_local_index  = local_ff;
   assign rsp_source_index = source_ff;
   assign rsp_new_vertex   = new_ff;
   assign rsp_last         = last_ff;

endmodule

### rtl/rvrc_ram.sv
// rvrc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rvrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/rvrc_lane.sv
// rvrc_lane: classifies one corner, range check and match against earlier corners
// depends on rvrc_pkg

module rvrc_lane
   import rvrc_pkg::*;
(
   input  logic [CORNER_W-1:0]            corner,
   input  logic [LIM_W-1:0]               limit,
   input  logic [CORNERS-2:0][CORNER_W-1:0] earlier,
   input  logic [CORNERS-2:0]             earlier_en,
   output lane_info_type                  info
);

   logic keep;

   assign keep = corner < CORNER_W'(limit);

   // earliest matching corner wins
   always_comb begin
      info.keep    = keep;
      info.dup     = 1'b0;
      info.dup_sel = '0;
      for (int i = CORNERS - 2; i >= 0; i--) begin
         if (keep && earlier_en[i] && (earlier[i] == corner)) begin
            info.dup     = 1'b1;
            info.dup_sel = IDX_W'(i);
         end
      end
   end

endmodule

### rtl/rvrc_merge.sv
// rvrc_merge: combines the lane results into the per-corner last flags
// depends on rvrc_pkg

module rvrc_merge
   import rvrc_pkg::*;
(
   input  lane_info_type      info [CORNERS],
   output logic [CORNERS-1:0] last_flag
);

   always_comb begin
      logic later_kept;
      later_kept = 1'b0;
      for (int i = CORNERS - 1; i >= 0; i--) begin
         last_flag[i] = info[i].keep && !later_kept;
         later_kept   = later_kept || info[i].keep;
      end
   end

endmodule
